// ===== rtl/sla_pkg.sv =====
// Shared types and constants for the slot lease allocator.
// Depends on nothing; sla_scan, sla_offset and the top level import it.
`timescale 1ns / 1ps
`default_nettype none
package sla_pkg;

	// Default pool size and fixed field widths.
	localparam int SLOTS_DEF = 64;
	localparam int CNT_OUT_W = 7;
	localparam int GSLOT_W   = 6;
	localparam int CMP_W     = 9;
	localparam int GROUP_W   = 8;

	// Configuration port geometry: registers at 8-byte steps.
	localparam int APB_AW = 6;
	localparam int APB_DW = 64;

	// Register indexes.
	localparam logic [2:0] REG_CRIT     = 3'd0;
	localparam logic [2:0] REG_INFLIGHT = 3'd1;
	localparam logic [2:0] REG_LIFETIME = 3'd2;
	localparam logic [2:0] REG_BASE     = 3'd3;
	localparam logic [2:0] REG_BYTES    = 3'd4;

	// Request codes.
	typedef enum logic [2:0] {
		OP_ACQUIRE = 3'd0,
		OP_ATTACH  = 3'd1,
		OP_RELEASE = 3'd2,
		OP_RECLAIM = 3'd3,
		OP_REHEAT  = 3'd4
	} op_t;

	// Result status codes.
	typedef enum logic [2:0] {
		ST_OK     = 3'd0,
		ST_NOFREE = 3'd1,
		ST_BUSY   = 3'd2,
		ST_ERROR  = 3'd3,
		ST_GENMIS = 3'd4,
		ST_STALE  = 3'd5,
		ST_EMPTY  = 3'd6
	} status_t;

	// Slot phases; free-hot is zero so a cleared entry reads as hot.
	typedef enum logic [1:0] {
		PH_HOT      = 2'd0,
		PH_FLIGHT   = 2'd1,
		PH_ATTACHED = 2'd2,
		PH_COOL     = 2'd3
	} phase_t;

	// One metadata word per slot.
	typedef struct packed {
		phase_t      phase;
		logic [15:0] owner;
		logic [31:0] gen;
		logic [31:0] lease;
	} meta_t;

endpackage
`default_nettype wire

// ===== rtl/sla_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
module sla_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                       clk,
	input  wire logic                       we,
	input  wire logic [$clog2(DEPTH)-1:0]   waddr,
	input  wire logic [WIDTH-1:0]           wdata,
	input  wire logic [$clog2(DEPTH)-1:0]   raddr,
	output logic      [WIDTH-1:0]           rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

// ===== rtl/sla_scan.sv =====
// Two-step search for the lowest free slot: a registered group pick, then a bit pick.
// Depends on sla_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sla_scan
	import sla_pkg::*;
#(
	parameter int SLOTS = SLOTS_DEF
) (
	input  wire logic                       clk,
	input  wire logic [SLOTS-1:0]           free_map,
	output logic                            found,
	output logic      [$clog2(SLOTS)-1:0]   pick_idx
);

	localparam int SW = $clog2(SLOTS);
	localparam int NG = (SLOTS + GROUP_W - 1) / GROUP_W;
	localparam int GW = (NG > 1) ? $clog2(NG) : 1;
	localparam int BW = $clog2(GROUP_W);

	logic [NG*GROUP_W-1:0] padded;
	logic [NG-1:0]         grp_any;
	logic [GW-1:0]         grp_sel;
	logic                  grp_hit;
	logic [GW-1:0]         grp_s1;
	logic                  hit_s1;
	logic [GROUP_W-1:0]    bits_s1;
	logic [BW-1:0]         bit_sel;
	logic                  bit_hit;

	// Lowest group holding a free slot.
	always_comb begin
		padded = '0;
		padded[SLOTS-1:0] = free_map;
		grp_sel = '0;
		grp_hit = 1'b0;
		for (int g = NG - 1; g >= 0; g--) begin
			grp_any[g] = |padded[g*GROUP_W +: GROUP_W];
			if (grp_any[g]) begin
				grp_sel = GW'(g);
				grp_hit = 1'b1;
			end
		end
	end

	// First step is registered every cycle.
	always_ff @(posedge clk) begin
		grp_s1  <= grp_sel;
		hit_s1  <= grp_hit;
		bits_s1 <= padded[grp_sel*GROUP_W +: GROUP_W];
	end

	// Lowest free bit inside the chosen group.
	always_comb begin
		bit_sel = '0;
		bit_hit = 1'b0;
		for (int b = GROUP_W - 1; b >= 0; b--) begin
			if (bits_s1[b]) begin
				bit_sel = BW'(b);
				bit_hit = 1'b1;
			end
		end
	end

	assign found    = hit_s1 & bit_hit;
	assign pick_idx = SW'({grp_s1, bit_sel});

endmodule
`default_nettype wire

// ===== rtl/sla_offset.sv =====
// Offset unit: slot index times slot size, then plus the region base.
// Depends on sla_pkg for the default pool size.
`timescale 1ns / 1ps
`default_nettype none
module sla_offset
	import sla_pkg::*;
#(
	parameter int SLOTS = SLOTS_DEF
) (
	input  wire logic                       clk,
	input  wire logic [$clog2(SLOTS)-1:0]   idx,
	input  wire logic [31:0]                slot_bytes,
	input  wire logic [31:0]                region_base,
	output logic      [63:0]                offset
);

	localparam int SW = $clog2(SLOTS);

	logic [SW+31:0] prod_s1;
	logic [63:0]    sum_s2;

	// Multiply, register, add, register.
	always_ff @(posedge clk) begin
		prod_s1 <= idx * slot_bytes;
		sum_s2  <= 64'(region_base) + 64'(prod_s1);
	end

	assign offset = sum_s2;

endmodule
`default_nettype wire

// ===== rtl/slot_lease_allocator.sv =====
// Top level of the slot lease allocator: sequencer, counters, config registers.
// Depends on sla_pkg, sla_ram, sla_scan and sla_offset.
// Steps: refusals and bad ops go straight to done; attach/release/reclaim: metadata;
// reheat: queue read, metadata, multiply; a granted acquire: find, metadata, multiply.
// Throughput: one word at a time; busy stays high until the strobe cycle ends and the
// receiver cannot stall, so the next word is taken once the sequencer is back in idle.
// Reset: all slots hot, queue empty, registers at defaults; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module slot_lease_allocator
	import sla_pkg::*;
#(
	parameter int SLOTS = SLOTS_DEF
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    start,
	output logic                         busy,
	input  wire logic [2:0]              op,
	input  wire logic [15:0]             requester,
	input  wire logic [7:0]              slot,
	input  wire logic [31:0]             generation,
	input  wire logic [31:0]             lease,
	output logic                         done,
	output logic      [2:0]              status,
	output logic      [GSLOT_W-1:0]      granted_slot,
	output logic      [31:0]             granted_generation,
	output logic      [63:0]             byte_offset,
	output logic      [31:0]             granted_lease,
	output logic      [63:0]             lease_ttl,
	output logic      [CNT_OUT_W-1:0]    hot_count,
	output logic      [CNT_OUT_W-1:0]    flight_count,
	output logic      [CNT_OUT_W-1:0]    attach_count,
	input  wire logic                    psel,
	input  wire logic                    penable,
	input  wire logic                    pwrite,
	input  wire logic [APB_AW-1:0]       paddr,
	input  wire logic [APB_DW-1:0]       pwdata,
	output logic      [APB_DW-1:0]       prdata,
	output logic                         pready
);

	localparam int SW = $clog2(SLOTS);
	localparam int CW = $clog2(SLOTS + 1);

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_FIND  = 6'b000010,
		S_QREAD = 6'b000100,
		S_META  = 6'b001000,
		S_MUL   = 6'b010000,
		S_DONE  = 6'b100000
	} state_t;

	state_t         state_q;
	logic [6:0]     crit_q;
	logic [6:0]     inflight_q;
	logic [63:0]    lifetime_q;
	logic [31:0]    base_q;
	logic [31:0]    bytes_q;

	logic [SLOTS-1:0] free_q;
	logic [SLOTS-1:0] vld_q;
	logic             rd_vld_q;
	logic [31:0]      next_lease_q;
	logic [SW-1:0]    head_q;
	logic [SW-1:0]    tail_q;
	logic [CW-1:0]    fill_q;
	logic [CW-1:0]    hot_q;
	logic [CW-1:0]    flight_q;
	logic [CW-1:0]    attach_q;

	logic [2:0]       op_q;
	logic [15:0]      who_q;
	logic [31:0]      gen_q;
	logic [31:0]      lease_q;
	logic [SW-1:0]    slot_q;
	status_t          status_q;
	logic             grant_q;
	logic [31:0]      ggen_q;
	logic [31:0]      glease_q;
	logic [63:0]      gttl_q;

	logic             cfg_wr;
	logic             accept;
	logic             found;
	logic [SW-1:0]    pick_idx;
	logic [SW-1:0]    meta_raddr;
	meta_t            meta_rdata;
	meta_t            meta_cur;
	meta_t            meta_wdata;
	logic             meta_we;
	logic             fifo_we;
	logic [SW-1:0]    fifo_rdata;
	logic [63:0]      offset;
	logic             slot_ok;
	logic             own_ok;
	logic             gen_ok;
	logic             lease_ok;
	logic             live_ph;

	// Configuration port.
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crit_q     <= 7'd6;
			inflight_q <= 7'd32;
			lifetime_q <= '0;
			base_q     <= 32'd4096;
			bytes_q    <= 32'd4096;
		end else if (cfg_wr) begin
			case (paddr[5:3])
				REG_CRIT:     crit_q     <= pwdata[6:0];
				REG_INFLIGHT: inflight_q <= pwdata[6:0];
				REG_LIFETIME: lifetime_q <= pwdata;
				REG_BASE:     base_q     <= pwdata[31:0];
				REG_BYTES:    bytes_q    <= pwdata[31:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[5:3])
			REG_CRIT:     prdata = 64'(crit_q);
			REG_INFLIGHT: prdata = 64'(inflight_q);
			REG_LIFETIME: prdata = lifetime_q;
			REG_BASE:     prdata = 64'(base_q);
			REG_BYTES:    prdata = 64'(bytes_q);
			default:      prdata = '0;
		endcase
	end

	// Storage and shared units.
	sla_ram #(.WIDTH($bits(meta_t)), .DEPTH(SLOTS)) u_meta (
		.clk   (clk),
		.we    (meta_we),
		.waddr (slot_q),
		.wdata (meta_wdata),
		.raddr (meta_raddr),
		.rdata (meta_rdata)
	);

	sla_ram #(.WIDTH(SW), .DEPTH(SLOTS)) u_fifo (
		.clk   (clk),
		.we    (fifo_we),
		.waddr (tail_q),
		.wdata (slot_q),
		.raddr (head_q),
		.rdata (fifo_rdata)
	);

	sla_scan #(.SLOTS(SLOTS)) u_scan (
		.clk      (clk),
		.free_map (free_q),
		.found    (found),
		.pick_idx (pick_idx)
	);

	sla_offset #(.SLOTS(SLOTS)) u_offset (
		.clk         (clk),
		.idx         (slot_q),
		.slot_bytes  (bytes_q),
		.region_base (base_q),
		.offset      (offset)
	);

	// Metadata read address follows the sequencer step.
	always_comb begin
		case (state_q)
			S_IDLE:  meta_raddr = slot[SW-1:0];
			S_FIND:  meta_raddr = pick_idx;
			S_QREAD: meta_raddr = fifo_rdata;
			default: meta_raddr = slot_q;
		endcase
	end

	// An entry never written reads as a free-hot slot with zero fields.
	assign meta_cur = rd_vld_q ? meta_rdata : meta_t'('0);
	assign slot_ok  = 9'(slot) < 9'(SLOTS);
	assign own_ok   = meta_cur.owner == who_q;
	assign gen_ok   = meta_cur.gen == gen_q;
	assign lease_ok = meta_cur.lease == lease_q;
	assign live_ph  = (meta_cur.phase == PH_FLIGHT) || (meta_cur.phase == PH_ATTACHED);
	assign accept   = start & ~busy;

	// Metadata and queue writes issued in the metadata step.
	always_comb begin
		meta_we    = 1'b0;
		fifo_we    = 1'b0;
		meta_wdata = meta_cur;
		if (state_q == S_META) begin
			case (op_t'(op_q))
				OP_ACQUIRE: begin
					meta_we          = 1'b1;
					meta_wdata.phase = PH_FLIGHT;
					meta_wdata.owner = who_q;
					meta_wdata.lease = next_lease_q;
				end
				OP_ATTACH: begin
					if (own_ok && gen_ok && lease_ok && meta_cur.phase == PH_FLIGHT) begin
						meta_we          = 1'b1;
						meta_wdata.phase = PH_ATTACHED;
					end
				end
				OP_RELEASE, OP_RECLAIM: begin
					if (own_ok && gen_ok && lease_ok && live_ph) begin
						meta_we          = 1'b1;
						fifo_we          = fill_q != CW'(SLOTS);
						meta_wdata.phase = PH_COOL;
						meta_wdata.owner = '0;
						meta_wdata.lease = '0;
						meta_wdata.gen   = meta_cur.gen + 32'd1;
					end
				end
				OP_REHEAT: begin
					if (meta_cur.phase == PH_COOL) begin
						meta_we          = 1'b1;
						meta_wdata.phase = PH_HOT;
					end
				end
				default: ;
			endcase
		end
	end

	// Sequencer, pool state and result registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			free_q       <= '1;
			vld_q        <= '0;
			rd_vld_q     <= 1'b0;
			next_lease_q <= 32'd1;
			head_q       <= '0;
			tail_q       <= '0;
			fill_q       <= '0;
			hot_q        <= CW'(SLOTS);
			flight_q     <= '0;
			attach_q     <= '0;
			status_q     <= ST_OK;
			grant_q      <= 1'b0;
		end else begin
			rd_vld_q <= vld_q[meta_raddr];
			if (meta_we) begin
				vld_q[slot_q] <= 1'b1;
			end
			if (fifo_we) begin
				tail_q <= (tail_q == SW'(SLOTS - 1)) ? '0 : tail_q + 1'b1;
				fill_q <= fill_q + 1'b1;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						grant_q <= 1'b0;
						case (op_t'(op))
							OP_ACQUIRE: begin
								if (hot_q == '0) begin
									status_q <= ST_NOFREE;
									state_q  <= S_DONE;
								end else if (CMP_W'(hot_q) <= CMP_W'(crit_q) ||
										CMP_W'(flight_q) >= CMP_W'(inflight_q)) begin
									status_q <= ST_BUSY;
									state_q  <= S_DONE;
								end else begin
									state_q <= S_FIND;
								end
							end
							OP_ATTACH, OP_RELEASE, OP_RECLAIM: begin
								slot_q <= slot[SW-1:0];
								if (slot_ok) begin
									state_q <= S_META;
								end else begin
									status_q <= ST_ERROR;
									state_q  <= S_DONE;
								end
							end
							OP_REHEAT: begin
								if (fill_q == '0) begin
									status_q <= ST_EMPTY;
									state_q  <= S_DONE;
								end else begin
									state_q <= S_QREAD;
								end
							end
							default: begin
								status_q <= ST_ERROR;
								state_q  <= S_DONE;
							end
						endcase
					end
				end
				S_FIND: begin
					slot_q <= pick_idx;
					if (found) begin
						state_q <= S_META;
					end else begin
						status_q <= ST_NOFREE;
						state_q  <= S_DONE;
					end
				end
				S_QREAD: begin
					slot_q  <= fifo_rdata;
					head_q  <= (head_q == SW'(SLOTS - 1)) ? '0 : head_q + 1'b1;
					fill_q  <= fill_q - 1'b1;
					state_q <= S_META;
				end
				S_META: begin
					state_q <= S_DONE;
					case (op_t'(op_q))
						OP_ACQUIRE: begin
							free_q[slot_q] <= 1'b0;
							next_lease_q   <= next_lease_q + 32'd1;
							hot_q          <= hot_q - 1'b1;
							flight_q       <= flight_q + 1'b1;
							status_q       <= ST_OK;
							grant_q        <= 1'b1;
							state_q        <= S_MUL;
						end
						OP_ATTACH: begin
							if (!own_ok) begin
								status_q <= ST_ERROR;
							end else if (!gen_ok) begin
								status_q <= ST_GENMIS;
							end else if (!lease_ok || meta_cur.phase != PH_FLIGHT) begin
								status_q <= ST_STALE;
							end else begin
								if (flight_q != '0) begin
									flight_q <= flight_q - 1'b1;
								end
								attach_q <= attach_q + 1'b1;
								status_q <= ST_OK;
							end
						end
						OP_RELEASE, OP_RECLAIM: begin
							if (!own_ok) begin
								status_q <= (op_q == OP_RELEASE) ? ST_ERROR : ST_STALE;
							end else if (!gen_ok) begin
								status_q <= (op_q == OP_RELEASE) ? ST_GENMIS : ST_STALE;
							end else if (!lease_ok || !live_ph) begin
								status_q <= ST_STALE;
							end else begin
								free_q[slot_q] <= 1'b0;
								if (meta_cur.phase == PH_FLIGHT && flight_q != '0) begin
									flight_q <= flight_q - 1'b1;
								end
								if (meta_cur.phase == PH_ATTACHED && attach_q != '0) begin
									attach_q <= attach_q - 1'b1;
								end
								status_q <= ST_OK;
							end
						end
						OP_REHEAT: begin
							if (meta_cur.phase == PH_COOL) begin
								free_q[slot_q] <= 1'b1;
								hot_q          <= hot_q + 1'b1;
							end
							status_q <= ST_OK;
							grant_q  <= 1'b1;
							state_q  <= S_MUL;
						end
						default: ;
					endcase
				end
				S_MUL: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Request payload and grant data.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q     <= op;
			who_q    <= requester;
			gen_q    <= generation;
			lease_q  <= lease;
			ggen_q   <= '0;
			glease_q <= '0;
			gttl_q   <= '0;
		end
		if (state_q == S_META && (op_q == OP_ACQUIRE || op_q == OP_REHEAT)) begin
			ggen_q <= meta_cur.gen;
			if (op_q == OP_ACQUIRE) begin
				glease_q <= next_lease_q;
				gttl_q   <= lifetime_q;
			end
		end
	end

	// Result word.
	assign busy               = state_q != S_IDLE;
	assign done               = state_q == S_DONE;
	assign status             = status_q;
	assign granted_slot       = grant_q ? GSLOT_W'(slot_q) : '0;
	assign granted_generation = ggen_q;
	assign byte_offset        = grant_q ? offset : '0;
	assign granted_lease      = glease_q;
	assign lease_ttl          = gttl_q;
	assign hot_count          = CNT_OUT_W'(hot_q);
	assign flight_count       = CNT_OUT_W'(flight_q);
	assign attach_count       = CNT_OUT_W'(attach_q);

	// The three phase totals never exceed the pool.
	a_totals: assert property (@(posedge clk) disable iff (!arst_n)
		(CMP_W'(hot_q) + CMP_W'(flight_q) + CMP_W'(attach_q)) <= CMP_W'(SLOTS))
		else $error("phase totals exceed the pool");

	// The queue never holds more entries than there are slots.
	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CW'(SLOTS))
		else $error("reheat queue overfilled");

	// A granted acquire leaves its slot marked as taken.
	a_acq: assert property (@(posedge clk) disable iff (!arst_n)
		done && status_q == ST_OK && op_q == OP_ACQUIRE |-> !free_q[slot_q])
		else $error("acquired slot still free");

	// An accepted word makes the block busy on the next cycle.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("accepted word did not start the sequencer");

endmodule
`default_nettype wire
